>>> rtl/block_cipher_encrypt_core_assert.svh
// assertion macros for the block cipher encrypt core
`ifndef BLOCK_CIPHER_ENCRYPT_CORE_ASSERT_SVH
`define BLOCK_CIPHER_ENCRYPT_CORE_ASSERT_SVH

// implication checked while out of reset
`define BCE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bce assertion failed");

// next-cycle implication checked while out of reset
`define BCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bce assertion failed");

// implication checked in and out of reset
`define BCE_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("bce assertion failed");

`endif

>>> rtl/bce_pkg.sv
// shared types, constants and byte functions of the aes encrypt core
package bce_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int MAX_WORDS  = 4 * (NUM_ROUNDS + 1);
  localparam int WORD_IDX_W = $clog2(MAX_WORDS);

  typedef logic [7:0]   byte_t;
  typedef logic [31:0]  word_t;
  typedef logic [127:0] block_t;
  typedef logic [3:0]   rnd_t;

  typedef enum logic [2:0] {
    REG_KEY_A = 3'd0,
    REG_KEY_B = 3'd1,
    REG_KEY_C = 3'd2,
    REG_KEY_D = 3'd3,
    REG_MODE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_128 = 2'd0,
    MODE_192 = 2'd1,
    MODE_256 = 2'd2
  } key_mode_t;

  // control that travels down the round chain beside the block
  typedef struct packed {
    logic valid;
    rnd_t nr;
  } ctl_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xt(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

>>> rtl/bce_keyexp.sv
// key schedule: one round key word per cycle into a round key register file
module bce_keyexp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [1:0]           mode_i,
  input  logic [255:0]         key_i,
  output logic                 busy_o,
  output bce_pkg::word_t       rk_o [bce_pkg::MAX_WORDS]
);
  import bce_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [WORD_IDX_W-1:0] i_r, i_nxt;
  logic [2:0]            j_r, j_nxt;
  byte_t                 rcon_r, rcon_nxt;
  word_t                 win_r [8];
  word_t                 rk_r [MAX_WORDS];
  word_t                 new_w, t_w;
  logic [2:0]            nk_m1;
  logic [WORD_IDX_W-1:0] last_idx;
  logic                  loading;

  always_comb begin
    unique case (mode_i)
      MODE_128: begin
        nk_m1    = 3'd3;
        last_idx = WORD_IDX_W'(43);
      end
      MODE_192: begin
        nk_m1    = 3'd5;
        last_idx = WORD_IDX_W'(51);
      end
      default: begin
        nk_m1    = 3'd7;
        last_idx = WORD_IDX_W'(59);
      end
    endcase
  end

  assign loading = ({3'd0, i_r} <= {6'd0, nk_m1});

  always_comb begin
    t_w      = win_r[0];
    rcon_nxt = rcon_r;
    if (j_r == 3'd0) begin
      t_w      = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'd0};
      rcon_nxt = xt(rcon_r);
    end else if (nk_m1 == 3'd7 && j_r == 3'd4) begin
      t_w = sub_word(win_r[0]);
    end
    if (loading) begin
      new_w    = key_i[255 - 32 * i_r[2:0] -: 32];
      rcon_nxt = rcon_r;
    end else begin
      new_w = win_r[nk_m1] ^ t_w;
    end
    i_nxt    = i_r + 1'b1;
    j_nxt    = (j_r == nk_m1) ? 3'd0 : j_r + 3'd1;
    busy_nxt = (i_r != last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start_i) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      j_r    <= '0;
      rcon_r <= 8'h01;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      rcon_r <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && rst_n && !start_i) begin
      rk_r[i_r] <= new_w;
      win_r[0]  <= new_w;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
    end
  end

  assign busy_o = busy_r;
  assign rk_o   = rk_r;

endmodule

>>> rtl/bce_round.sv
// one cipher round cell: subbytes, shiftrows, mixcolumns, round key add (last round without mixcolumns)
module bce_round #(
  parameter int RND = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en_i,
  input  bce_pkg::ctl_t   ctl_i,
  input  bce_pkg::block_t state_i,
  input  bce_pkg::block_t rkey_i,
  output bce_pkg::ctl_t   ctl_o,
  output bce_pkg::block_t state_o
);
  import bce_pkg::*;

  ctl_t   ctl_r;
  block_t state_r, state_nxt, sr, mc;
  byte_t  a0, a1, a2, a3, all;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8 * (r + 4 * c) -: 8] = SBOX[state_i[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = sr[127 - 32 * c -: 8];
      a1  = sr[119 - 32 * c -: 8];
      a2  = sr[111 - 32 * c -: 8];
      a3  = sr[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32 * c -: 8] = a0 ^ all ^ xt(a0 ^ a1);
      mc[119 - 32 * c -: 8] = a1 ^ all ^ xt(a1 ^ a2);
      mc[111 - 32 * c -: 8] = a2 ^ all ^ xt(a2 ^ a3);
      mc[103 - 32 * c -: 8] = a3 ^ all ^ xt(a3 ^ a0);
    end
    // rounds past the last one of a short key just pass the block on
    if (rnd_t'(RND) < ctl_i.nr)       state_nxt = mc ^ rkey_i;
    else if (rnd_t'(RND) == ctl_i.nr) state_nxt = sr ^ rkey_i;
    else                              state_nxt = state_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      ctl_r.nr    <= '0;
    end else if (en_i) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) state_r <= state_nxt;
  end

  assign ctl_o   = ctl_r;
  assign state_o = state_r;

endmodule

>>> rtl/block_cipher_encrypt_core.sv
// aes-128/192/256 encrypt core, one block per cycle through a chain of round cells
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid/in_ready   | in_plain_high, in_plain_low
//  out     | out_valid/out_ready | out_cipher_high, out_cipher_low
//  cfg     | cfg_we              | cfg_addr, cfg_data
//
//  a new block every cycle while in_ready is high; a key add stage plus 14 round cells
//  the round keys come from a key schedule that makes one word a cycle, 44, 52 or
//  60 words; after reset or any cfg write, in_ready is low until it is done
//  the whole chain moves as one; it holds while out_valid is high and out_ready low
//  reset is synchronous, active low, and clears the valid bits and key registers
module block_cipher_encrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data
);
  import bce_pkg::*;

  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r;
  logic [1:0]  mode_r;
  logic        ks_busy;
  word_t       rk [MAX_WORDS];
  logic        adv;
  rnd_t        nr;

  // chain links: index 0 is the initial key add, 1..14 the round cells
  ctl_t   ctl   [NUM_ROUNDS + 1];
  block_t state [NUM_ROUNDS + 1];
  ctl_t   ctl0_r;
  block_t state0_r;

  // key and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
      mode_r  <= MODE_128;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_A: key_a_r <= cfg_data;
        REG_KEY_B: key_b_r <= cfg_data;
        REG_KEY_C: key_c_r <= cfg_data;
        REG_KEY_D: key_d_r <= cfg_data;
        REG_MODE:  mode_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_128: nr = 4'd10;
      MODE_192: nr = 4'd12;
      default:  nr = 4'd14;
    endcase
  end

  bce_keyexp u_keyexp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cfg_we),
    .mode_i  (mode_r),
    .key_i   ({key_a_r, key_b_r, key_c_r, key_d_r}),
    .busy_o  (ks_busy),
    .rk_o    (rk)
  );

  // the chain advances unless a finished block waits at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !ks_busy;

  // stage 0: initial round key add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
      ctl0_r.nr    <= '0;
    end else if (adv) begin
      ctl0_r.valid <= in_valid && in_ready;
      ctl0_r.nr    <= nr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) state0_r <= {in_plain_high, in_plain_low} ^ {rk[0], rk[1], rk[2], rk[3]};
  end

  assign ctl[0]   = ctl0_r;
  assign state[0] = state0_r;

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    bce_round #(.RND(g)) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en_i    (adv),
      .ctl_i   (ctl[g-1]),
      .state_i (state[g-1]),
      .rkey_i  ({rk[4*g], rk[4*g+1], rk[4*g+2], rk[4*g+3]}),
      .ctl_o   (ctl[g]),
      .state_o (state[g])
    );
  end

  // last cell is the output register
  assign out_valid       = ctl[NUM_ROUNDS].valid;
  assign out_cipher_high = state[NUM_ROUNDS][127:64];
  assign out_cipher_low  = state[NUM_ROUNDS][63:0];

endmodule

>>> rtl/bce_checker.sv
// port-level checks for the encrypt core, bound to the top level
`include "block_cipher_encrypt_core_assert.svh"

module bce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [63:0] in_plain_high,
  input logic [63:0] in_plain_low,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_high,
  input logic [63:0] out_cipher_low,
  input logic        cfg_we,
  input logic [2:0]  cfg_addr,
  input logic [63:0] cfg_data
);

  // a stalled result stays valid and its low half holds
  `BCE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cipher_low))
  // key schedule restarts after any cfg write, which blocks the input
  `BCE_ASSERT_NXT(a_cfg_blocks, cfg_we, !in_ready)
  // no input while a result waits stalled
  `BCE_ASSERT(a_ready_stall, in_ready, out_ready || !out_valid)
  // right after reset the key schedule is still running
  `BCE_ASSERT_ALWAYS(a_rst_busy, $past(!rst_n), !in_ready && !out_valid)

endmodule

bind block_cipher_encrypt_core bce_checker u_bce_checker (.*);
